// ----- rtl/core/lras_pkg.sv -----
// lras_pkg: shared types and constants for the line rasterizer.
// Holds coordinate/address widths, operation and format codes, and the
// input/result transfer structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lras_pkg;

	// Fixed field widths
	localparam int COORD_BITS    = 16;
	localparam int ADDR_BITS     = 48;
	localparam int CHAN_BITS     = 8;
	localparam int COLOR_BITS    = 3 * CHAN_BITS;
	localparam int PPL_BITS      = 16;
	localparam int FMT_BITS      = 2;
	localparam int SPAN_BITS     = COORD_BITS + 1;
	localparam int PROD_BITS     = 2 * COORD_BITS + 1;
	localparam int OFF_BITS      = 2 * COORD_BITS + 2;
	localparam int CFG_DATA_BITS = ADDR_BITS;
	localparam int CFG_IDX_BITS  = 2;

	// Operation codes
	typedef enum logic {
		OP_START = 1'b0,
		OP_STEP  = 1'b1
	} op_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_FB_BASE   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PPL       = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_FMT = 2'd2;

	// Pixel formats
	localparam logic [FMT_BITS-1:0] FMT_RGB = 2'd0;
	localparam logic [FMT_BITS-1:0] FMT_BGR = 2'd1;

	// Reset value of the row stride
	localparam logic [PPL_BITS-1:0] PPL_RESET = 16'd1024;

	// One input transfer
	typedef struct packed {
		logic                         operation;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic [CHAN_BITS-1:0]         red;
		logic [CHAN_BITS-1:0]         green;
		logic [CHAN_BITS-1:0]         blue;
	} in_item_t;

	// One framebuffer write
	typedef struct packed {
		logic [ADDR_BITS-1:0]         write_address;
		logic [COLOR_BITS-1:0]        pixel_word;
		logic                         write_enable;
		logic signed [COORD_BITS-1:0] pixel_x;
		logic signed [COORD_BITS-1:0] pixel_y;
		logic                         last;
	} out_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/line_rasterizer.sv -----
// line_rasterizer: Bresenham line walker emitting one framebuffer write per step.
// Depends on lras_pkg for field widths, codes and the transfer structs.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): a start transfer loads both
//   endpoints and the colour and produces no result; each following step
//   transfer produces one pixel write on the output channel. A step with no
//   line active is consumed and produces nothing. A start mid-line drops the
//   rest of the old line.
//   Output channel (out_valid / out_stall / out_data): one write per step, with
//   byte address fb_base + 4*(x + y*pixels_per_line), packed colour, and last
//   set on the final pixel. Unsupported formats give write_enable 0, word 0.
//   Configuration (cfg_write / cfg_index / cfg_data): write only while idle.
// Pipeline and throughput:
//   A step's result is registered through the walker stage, offset
//   multiply, address add into the output register. One item is accepted
//   per cycle while in_stall is low; the line state update (one 18-bit
//   add and compare) sets that rate, the stride multiply sits in its own stage.
// Reset sets the configuration, walker and valid registers to their defaults
// (stride 1024) and leaves no line active. When the receiver stalls, the
// pipeline fills its empty stages and then holds the input with in_stall.
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// Input channel
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  lras_pkg::in_item_t                  in_data,
	// Output channel
	output logic                                out_valid,
	input  wire                                 out_stall,
	output lras_pkg::out_item_t                 out_data,
	// Configuration write port
	input  wire                                 cfg_write,
	input  wire  [lras_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire  [lras_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import lras_pkg::*;

	// Configuration registers
	logic [ADDR_BITS-1:0] fb_base_q;
	logic [PPL_BITS-1:0]  ppl_q;
	logic [FMT_BITS-1:0]  fmt_q;

	// Line walker state
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
	logic [SPAN_BITS-1:0]         major_q, minor_q, err_q, left_q;
	logic                         x_major_q, x_neg_q, y_neg_q;
	logic [COLOR_BITS-1:0]        colour_q;

	// Pipeline stages
	logic                         valid_s1, valid_s2;
	logic signed [COORD_BITS-1:0] x_s1, y_s1, x_s2, y_s2;
	logic [COLOR_BITS-1:0]        colour_s1, colour_s2;
	logic                         last_s1, last_s2;
	logic signed [OFF_BITS-1:0]   off_s2;

	// Handshake / stage advance
	logic out_free, s2_free, s1_free, in_xfer, is_start, is_step;

	assign out_free = !out_valid || !out_stall;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_stall = !s1_free;
	assign in_xfer  = in_valid && s1_free;
	assign is_start = in_xfer && (op_t'(in_data.operation) == OP_START);
	assign is_step  = in_xfer && (op_t'(in_data.operation) == OP_STEP) && (left_q != '0);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_base_q <= '0;
			ppl_q     <= PPL_RESET;
			fmt_q     <= FMT_RGB;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_FB_BASE:   fb_base_q <= cfg_data[ADDR_BITS-1:0];
				CFG_PPL:       ppl_q     <= cfg_data[PPL_BITS-1:0];
				CFG_PIXEL_FMT: fmt_q     <= cfg_data[FMT_BITS-1:0];
				default:       ;
			endcase
		end
	end

	// Line setup from the endpoints
	logic signed [SPAN_BITS-1:0] dx_c, dy_c;
	logic [SPAN_BITS-1:0]        adx_c, ady_c, sx_c, sy_c;
	logic                        x_major_c;

	always_comb begin
		dx_c = {in_data.end_x[COORD_BITS-1], in_data.end_x}
		     - {in_data.start_x[COORD_BITS-1], in_data.start_x};
		dy_c = {in_data.end_y[COORD_BITS-1], in_data.end_y}
		     - {in_data.start_y[COORD_BITS-1], in_data.start_y};
		adx_c = dx_c[SPAN_BITS-1] ? SPAN_BITS'(-dx_c) : SPAN_BITS'(dx_c);
		ady_c = dy_c[SPAN_BITS-1] ? SPAN_BITS'(-dy_c) : SPAN_BITS'(dy_c);
		sx_c  = adx_c + 1'b1;
		sy_c  = ady_c + 1'b1;
		x_major_c = (sx_c >= sy_c);
	end

	// One Bresenham step from the current state
	logic [SPAN_BITS:0]           err_sum_c;
	logic                         minor_step_c;
	logic signed [COORD_BITS-1:0] x_inc_c, y_inc_c, nx_c, ny_c;
	logic [SPAN_BITS-1:0]         nerr_c;

	always_comb begin
		err_sum_c    = {1'b0, err_q} + {1'b0, minor_q};
		minor_step_c = (err_sum_c >= {1'b0, major_q});
		nerr_c       = minor_step_c ? SPAN_BITS'(err_sum_c - {1'b0, major_q})
		                            : SPAN_BITS'(err_sum_c);
		x_inc_c = x_neg_q ? COORD_BITS'(cur_x_q - 1'b1) : COORD_BITS'(cur_x_q + 1'b1);
		y_inc_c = y_neg_q ? COORD_BITS'(cur_y_q - 1'b1) : COORD_BITS'(cur_y_q + 1'b1);
		nx_c = (x_major_q || minor_step_c) ? x_inc_c : cur_x_q;
		ny_c = (!x_major_q || minor_step_c) ? y_inc_c : cur_y_q;
	end

	// Walker state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			major_q   <= '0;
			minor_q   <= '0;
			err_q     <= '0;
			left_q    <= '0;
			x_major_q <= 1'b0;
			x_neg_q   <= 1'b0;
			y_neg_q   <= 1'b0;
			colour_q  <= '0;
		end else if (is_start) begin
			cur_x_q   <= in_data.start_x;
			cur_y_q   <= in_data.start_y;
			major_q   <= x_major_c ? sx_c : sy_c;
			minor_q   <= x_major_c ? sy_c : sx_c;
			err_q     <= '0;
			left_q    <= x_major_c ? sx_c : sy_c;
			x_major_q <= x_major_c;
			x_neg_q   <= dx_c[SPAN_BITS-1];
			y_neg_q   <= dy_c[SPAN_BITS-1];
			colour_q  <= {in_data.blue, in_data.green, in_data.red};
		end else if (is_step) begin
			cur_x_q <= nx_c;
			cur_y_q <= ny_c;
			err_q   <= nerr_c;
			left_q  <= left_q - 1'b1;
		end
	end

	// Stage 1: snapshot of the pixel being emitted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= is_step;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && is_step) begin
			x_s1      <= cur_x_q;
			y_s1      <= cur_y_q;
			colour_s1 <= colour_q;
			last_s1   <= (left_q == SPAN_BITS'(1));
		end
	end

	// Stage 2: pixel offset x + y * stride
	logic signed [PROD_BITS-1:0] prod_c;
	logic signed [OFF_BITS-1:0]  off_c;

	always_comb begin
		prod_c = $signed(y_s1) * $signed({1'b0, ppl_q});
		off_c  = OFF_BITS'(prod_c) + OFF_BITS'(x_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			off_s2    <= off_c;
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			colour_s2 <= colour_s1;
			last_s2   <= last_s1;
		end
	end

	// Output register: byte address and packed colour
	out_item_t res_c;

	always_comb begin
		res_c.write_address = fb_base_q + ADDR_BITS'($signed({off_s2, 2'b00}));
		res_c.pixel_x       = x_s2;
		res_c.pixel_y       = y_s2;
		res_c.last          = last_s2;
		case (fmt_q)
			FMT_RGB: begin
				res_c.pixel_word   = colour_s2;
				res_c.write_enable = 1'b1;
			end
			FMT_BGR: begin
				res_c.pixel_word   = {colour_s2[CHAN_BITS-1:0],
				                      colour_s2[2*CHAN_BITS-1:CHAN_BITS],
				                      colour_s2[COLOR_BITS-1:2*CHAN_BITS]};
				res_c.write_enable = 1'b1;
			end
			default: begin
				res_c.pixel_word   = '0;
				res_c.write_enable = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			out_data <= res_c;
		end
	end

endmodule

`default_nettype wire

// ----- dv/tb_line_rasterizer.sv -----
// tb_line_rasterizer: self-checking testbench for the Bresenham line rasterizer.
// Drives start/step transfers with bursty traffic against a stalling receiver and
// checks every pixel write against an in-bench line walker. Depends on lras_pkg.
`timescale 1ns / 1ps

module tb_line_rasterizer;
	import lras_pkg::*;

	localparam int SETTLE_CYCLES = 8;       // pipeline is 3 deep, allow margin
	localparam int CYCLE_LIMIT   = 300000;
	localparam int TARGET_ITEMS  = 550;
	localparam int MAX_REPORTS   = 10;
	// Index past the register list; writes there must be ignored
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 2'd3;
	// Format codes with no write support
	localparam logic [FMT_BITS-1:0] FMT_UNSUPPORTED    = 2'd2;
	localparam logic [FMT_BITS-1:0] FMT_UNSUPPORTED_HI = 2'd3;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	in_item_t                 in_data;
	logic                     out_valid;
	logic                     out_stall;
	out_item_t                out_data;
	logic                     cfg_write;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	line_rasterizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Line walker state, mirrored from the block's behavior
	logic [ADDR_BITS-1:0]  reg_fb_base;
	logic [PPL_BITS-1:0]   reg_ppl;
	logic [FMT_BITS-1:0]   reg_fmt;
	logic [COORD_BITS-1:0] walk_x;
	logic [COORD_BITS-1:0] walk_y;
	int                    walk_major;
	int                    walk_minor;
	int                    walk_err;
	int                    walk_left;
	bit                    walk_x_major;
	bit                    walk_x_neg;
	bit                    walk_y_neg;
	logic [COLOR_BITS-1:0] walk_colour;

	out_item_t pending_writes[$];
	int        write_mismatches;
	int        drawn_items;
	int        cycles;
	int        burst_left;

	// Apply one accepted transfer to the walker; queue the pixel write it causes
	task automatic rasterize_transfer(input in_item_t it);
		int        x1, y1, x2, y2, dx, dy, sx, sy;
		longint    xs, ys, offset, addr;
		out_item_t px;
		if (it.operation == OP_START) begin
			x1 = $signed(it.start_x);
			y1 = $signed(it.start_y);
			x2 = $signed(it.end_x);
			y2 = $signed(it.end_y);
			dx = x2 - x1;
			dy = y2 - y1;
			walk_x_neg = dx < 0;
			walk_y_neg = dy < 0;
			sx = (dx < 0 ? -dx : dx) + 1;
			sy = (dy < 0 ? -dy : dy) + 1;
			walk_x_major = sx >= sy;
			walk_major = walk_x_major ? sx : sy;
			walk_minor = walk_x_major ? sy : sx;
			walk_err = 0;
			walk_left = walk_major;
			walk_x = it.start_x;
			walk_y = it.start_y;
			walk_colour = {it.blue, it.green, it.red};
			drawn_items++;
			return;
		end
		// step with no line active is dropped
		if (walk_left == 0)
			return;
		drawn_items++;

		xs = $signed(walk_x);
		ys = $signed(walk_y);
		offset = xs + ys * longint'({16'd0, reg_ppl});
		addr = longint'({16'd0, reg_fb_base}) + 4 * offset;
		px.write_address = addr[ADDR_BITS-1:0];
		px.pixel_x = walk_x;
		px.pixel_y = walk_y;
		px.last = (walk_left == 1);
		if (reg_fmt == FMT_RGB) begin
			px.pixel_word = walk_colour;
			px.write_enable = 1'b1;
		end else if (reg_fmt == FMT_BGR) begin
			px.pixel_word = {walk_colour[7:0], walk_colour[15:8], walk_colour[23:16]};
			px.write_enable = 1'b1;
		end else begin
			px.pixel_word = '0;
			px.write_enable = 1'b0;
		end
		pending_writes.push_back(px);

		// major axis moves every pixel, minor when the error wraps
		walk_err += walk_minor;
		if (walk_x_major)
			walk_x = walk_x_neg ? walk_x - 1'b1 : walk_x + 1'b1;
		else
			walk_y = walk_y_neg ? walk_y - 1'b1 : walk_y + 1'b1;
		if (walk_err >= walk_major) begin
			walk_err -= walk_major;
			if (walk_x_major)
				walk_y = walk_y_neg ? walk_y - 1'b1 : walk_y + 1'b1;
			else
				walk_x = walk_x_neg ? walk_x - 1'b1 : walk_x + 1'b1;
		end
		walk_left--;
	endtask

	// One input transfer, with bursty gaps in front of it
	task automatic send_item(input in_item_t it);
		int gap;
		bit taken;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= it;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
		rasterize_transfer(it);
	endtask

	function automatic in_item_t random_item(input op_t op);
		logic [95:0] raw;
		in_item_t    it;
		raw = {$urandom, $urandom, $urandom};
		it = raw[$bits(in_item_t)-1:0];
		it.operation = op;
		return it;
	endfunction

	task automatic start_line(input logic [COORD_BITS-1:0] x1, input logic [COORD_BITS-1:0] y1,
			input logic [COORD_BITS-1:0] x2, input logic [COORD_BITS-1:0] y2,
			input logic [COLOR_BITS-1:0] rgb);
		in_item_t it;
		it = random_item(OP_START);
		it.start_x = x1;
		it.start_y = y1;
		it.end_x = x2;
		it.end_y = y2;
		{it.red, it.green, it.blue} = rgb;
		send_item(it);
	endtask

	task automatic step_line(input int n);
		repeat (n) send_item(random_item(OP_STEP));
	endtask

	// Hold the sender until every queued write has come out and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_FB_BASE:   reg_fb_base = value;
			CFG_PPL:       reg_ppl = value[PPL_BITS-1:0];
			CFG_PIXEL_FMT: reg_fmt = value[FMT_BITS-1:0];
			default: ;
		endcase
	endtask

	// Step while idle must be swallowed
	task automatic test_idle_step();
		step_line(1);
	endtask

	// Shallow, steep-negative and single-point lines under reset settings
	task automatic test_basic_lines();
		start_line(16'sd0, 16'sd0, 16'sd2, 16'sd1, 24'hFF00FF);
		step_line(3);
		start_line(16'sd3, -16'sd2, 16'sd2, -16'sd5, 24'h123456);
		step_line(4);
		start_line(-16'sd7, 16'sd9, -16'sd7, 16'sd9, 24'hA5C3E1);
		// one step past the end: idle again
		step_line(2);
	endtask

	// Coordinate extremes, and a new start cutting a line short
	task automatic test_extremes();
		start_line(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 24'h00FF00);
		step_line(3);
		start_line(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 24'hFF00FF);
		step_line(2);
		start_line(16'sd0, 16'sd0, 16'sd0, 16'sd1, 24'hFFFFFF);
		step_line(2);
		drain();
	endtask

	// Register extremes, both supported formats and an unsupported one
	task automatic test_registers();
		write_reg(CFG_FB_BASE, {ADDR_BITS{1'b1}});
		write_reg(CFG_PPL, 48'hFFFF);
		write_reg(CFG_PIXEL_FMT, {46'd0, FMT_BGR});
		write_reg(CFG_UNMAPPED, 48'hDEAD_BEEF_F00D);
		start_line(16'hFFFF, 16'hFFFF, 16'sd1, 16'hFFFF, 24'h0180FE);
		step_line(3);
		drain();
		write_reg(CFG_PIXEL_FMT, {46'd0, FMT_UNSUPPORTED});
		start_line(16'sd4, 16'sd4, 16'sd4, 16'sd4, 24'h7F7F7F);
		step_line(1);
		drain();
		write_reg(CFG_FB_BASE, 48'd0);
		write_reg(CFG_PPL, 48'd0);
		write_reg(CFG_PIXEL_FMT, {46'd0, FMT_RGB});
		start_line(16'sd5, 16'sd5, 16'sd6, 16'sd6, 24'h010203);
		step_line(2);
		drain();
	endtask

	// Random settings, extremes weighted in; upper data bits carry junk
	task automatic random_config();
		logic [63:0] r64;
		logic [15:0] ppl;
		int          pick;
		r64 = {$urandom, $urandom};
		pick = $urandom_range(0, 3);
		write_reg(CFG_FB_BASE, pick == 0 ? '0 : pick == 1 ? {ADDR_BITS{1'b1}} : r64[47:0]);
		pick = $urandom_range(0, 5);
		case (pick)
			0: ppl = 16'd0;
			1: ppl = 16'd1;
			2: ppl = 16'hFFFF;
			3: ppl = PPL_RESET;
			4: ppl = 16'($urandom_range(1, 2000));
			default: ppl = 16'($urandom);
		endcase
		r64 = {$urandom, $urandom};
		write_reg(CFG_PPL, {r64[31:0], ppl});
		pick = $urandom_range(0, 9);
		r64 = {$urandom, $urandom};
		write_reg(CFG_PIXEL_FMT, {r64[45:0], pick < 4 ? FMT_RGB : pick < 8 ? FMT_BGR :
			pick == 8 ? FMT_UNSUPPORTED : FMT_UNSUPPORTED_HI});
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_UNMAPPED, r64[47:0]);
	endtask

	// Mostly complete short lines, some long lines cut short, some noise
	task automatic test_random_traffic();
		int          kind, steps, phase_left;
		int          bx, by, dx, dy;
		logic [31:0] vx1, vy1, vx2, vy2;
		phase_left = $urandom_range(40, 90);
		while (drawn_items < TARGET_ITEMS) begin
			if (phase_left <= 0) begin
				// several phases also cover the hold-until-empty case
				drain();
				random_config();
				phase_left = $urandom_range(40, 90);
			end
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				if ($urandom_range(0, 2) == 0) begin
					bx = $urandom;
					by = $urandom;
				end else begin
					bx = $urandom_range(0, 100) - 50;
					by = $urandom_range(0, 100) - 50;
				end
				dx = $urandom_range(0, 24) - 12;
				dy = $urandom_range(0, 24) - 12;
				vx1 = bx;
				vy1 = by;
				vx2 = bx + dx;
				vy2 = by + dy;
				start_line(vx1[15:0], vy1[15:0], vx2[15:0], vy2[15:0], 24'($urandom));
				if (walk_left <= 64 && $urandom_range(0, 9) < 7)
					steps = walk_left + ($urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : 0);
				else
					steps = $urandom_range(1, walk_left < 8 ? walk_left : 8);
				step_line(steps);
			end else if (kind < 90) begin
				start_line(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					24'($urandom));
				step_line($urandom_range(1, 6));
			end else begin
				repeat ($urandom_range(1, 3))
					send_item(random_item($urandom_range(0, 1) ? OP_STEP : OP_START));
			end
			phase_left -= steps + 1;
			steps = 0;
		end
	endtask

	// Receiver stall pattern: runs of no stall, light, periodic and heavy stalling
	int stall_mode;
	int stall_run;
	int stall_phase;
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_run <= $urandom_range(20, 150);
		end else begin
			stall_run <= stall_run - 1;
		end
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= $urandom_range(0, 9) < 3;
			2: out_stall <= (stall_phase % 8) < 3;
			default: out_stall <= $urandom_range(0, 9) < 7;
		endcase
	end

	// Result checker: sample mid-cycle, a transfer happens at the next rising edge
	always @(negedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_writes.size() == 0) begin
				write_mismatches++;
				if (write_mismatches <= MAX_REPORTS)
					$display("unexpected pixel write: addr %h x %0d y %0d",
						out_data.write_address, out_data.pixel_x, out_data.pixel_y);
			end else begin
				want = pending_writes.pop_front();
				if (out_data.write_address !== want.write_address ||
						out_data.pixel_word !== want.pixel_word ||
						out_data.write_enable !== want.write_enable ||
						out_data.pixel_x !== want.pixel_x ||
						out_data.pixel_y !== want.pixel_y ||
						out_data.last !== want.last) begin
					write_mismatches++;
					if (write_mismatches <= MAX_REPORTS)
						$display({"pixel write mismatch: expected addr %h word %h we %b ",
							"x %0d y %0d last %b, got addr %h word %h we %b x %0d y %0d last %b"},
							want.write_address, want.pixel_word, want.write_enable,
							want.pixel_x, want.pixel_y, want.last,
							out_data.write_address, out_data.pixel_word,
							out_data.write_enable, out_data.pixel_x, out_data.pixel_y,
							out_data.last);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_FB_BASE;
		cfg_data = '0;
		stall_mode = 0;
		stall_run = 0;
		stall_phase = 0;
		cycles = 0;
		burst_left = 0;
		write_mismatches = 0;
		drawn_items = 0;
		reg_fb_base = '0;
		reg_ppl = PPL_RESET;
		reg_fmt = FMT_RGB;
		walk_x = '0;
		walk_y = '0;
		walk_major = 0;
		walk_minor = 0;
		walk_err = 0;
		walk_left = 0;
		walk_x_major = 1'b0;
		walk_x_neg = 1'b0;
		walk_y_neg = 1'b0;
		walk_colour = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_step();
		test_basic_lines();
		test_extremes();
		test_registers();
		test_random_traffic();
		drain();

		if (write_mismatches == 0 && pending_writes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
